// ===== hw/rtl/p2g_pkg.sv =====
// Shared types, widths and constants of the polar to grid coordinate unit.
// Holds the elaboration-time builder of the quarter-wave sine table.
// No dependencies.
package p2g_pkg;

  localparam int GRID_SIZE    = 128;
  localparam int ANGLE_STEPS  = 360;
  localparam int STRIP_LENGTH = 64;
  localparam int QUARTER_DEG  = 90;

  localparam int ANGLE_W  = 9;
  localparam int RADIUS_W = 6;
  localparam int CENTER_W = 7;
  localparam int COORD_W  = 8;
  localparam int FRAC_W   = 32;
  // magnitude of a quarter-wave value, up to and including 1.0
  localparam int MAG_W    = FRAC_W + 1;
  localparam int TRIG_W   = FRAC_W + 2;
  // centre * 2^32 + radius * trig, signed
  localparam int V_W      = 41;
  localparam int INT_W    = V_W - FRAC_W;
  localparam int QDEG_W   = 7;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam real PI_R = 3.14159265358979323846;
  localparam real Q32_ONE_R = 4294967296.0;

  typedef enum logic {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CENTER_W-1:0] pivot_col;
    logic [CENTER_W-1:0] pivot_row;
  } cfg_t;

  // sin of m degrees in Q32, rounded to nearest; evaluated at elaboration only
  function automatic logic [MAG_W-1:0] quarter_sin_q32(int unsigned m);
    real    ang;
    real    v;
    longint q;
    ang = real'(m) * PI_R / 180.0;
    v   = $sin(ang) * Q32_ONE_R;
    q   = longint'(v);
    return MAG_W'(q);
  endfunction

endpackage

// ===== hw/rtl/p2g_cfg.sv =====
// Configuration register file of the polar to grid coordinate unit.
// APB-style slave holding the rotation centre; uses p2g_pkg.
module p2g_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [p2g_pkg::APB_AW-1:0] paddr,
  input  logic [p2g_pkg::APB_DW-1:0] pwdata,
  output logic [p2g_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output p2g_pkg::cfg_t              cfg_o
);
  import p2g_pkg::*;

  logic [CENTER_W-1:0] pivot_col_q, pivot_col_d;
  logic [CENTER_W-1:0] pivot_row_q, pivot_row_d;
  reg_idx_e            reg_idx;
  logic                wr_en;

  // byte address 4*i, low address bits ignored
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    pivot_col_d = pivot_col_q;
    pivot_row_d = pivot_row_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X: pivot_col_d = pwdata[CENTER_W-1:0];
        REG_CENTER_Y: pivot_row_d = pwdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = APB_DW'(pivot_col_q);
      REG_CENTER_Y: prdata = APB_DW'(pivot_row_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_col_q <= CENTER_W'(32);
      pivot_row_q <= CENTER_W'(32);
    end else begin
      pivot_col_q <= pivot_col_d;
      pivot_row_q <= pivot_row_d;
    end
  end

  assign cfg_o.pivot_col = pivot_col_q;
  assign cfg_o.pivot_row = pivot_row_q;

endmodule

// ===== hw/rtl/p2g_trig_lookup.sv =====
// Sine of a whole degree (0..359) in signed Q32 from a quarter-wave table.
// Table built at elaboration from p2g_pkg.
module p2g_trig_lookup (
  input  logic [p2g_pkg::ANGLE_W-1:0]       deg_i,
  output logic signed [p2g_pkg::TRIG_W-1:0] sin_o
);
  import p2g_pkg::*;

  logic [MAG_W-1:0]  rom_w [QUARTER_DEG+1];
  logic [1:0]        quad;
  logic [QDEG_W-1:0] m;
  logic [QDEG_W-1:0] rom_idx;
  logic [MAG_W-1:0]  mag;
  logic signed [TRIG_W-1:0] mag_s;

  for (genvar g = 0; g <= QUARTER_DEG; g++) begin : g_rom
    localparam logic [MAG_W-1:0] Val = quarter_sin_q32(g);
    assign rom_w[g] = Val;
  end

  always_comb begin
    priority if (deg_i < ANGLE_W'(QUARTER_DEG)) begin
      quad = 2'd0;
      m    = QDEG_W'(deg_i);
    end else if (deg_i < ANGLE_W'(2*QUARTER_DEG)) begin
      quad = 2'd1;
      m    = QDEG_W'(deg_i - ANGLE_W'(QUARTER_DEG));
    end else if (deg_i < ANGLE_W'(3*QUARTER_DEG)) begin
      quad = 2'd2;
      m    = QDEG_W'(deg_i - ANGLE_W'(2*QUARTER_DEG));
    end else begin
      quad = 2'd3;
      m    = QDEG_W'(deg_i - ANGLE_W'(3*QUARTER_DEG));
    end
  end

  // odd quadrants mirror the quarter wave, the lower half plane negates it
  assign rom_idx = quad[0] ? QDEG_W'(QUARTER_DEG) - m : m;
  assign mag     = rom_w[rom_idx];
  assign mag_s   = $signed({1'b0, mag});
  assign sin_o   = quad[1] ? -mag_s : mag_s;

endmodule

// ===== hw/rtl/p2g_round_check.sv =====
// Rounds one Q32 coordinate half away from zero and checks it against the grid.
// Uses widths from p2g_pkg.
module p2g_round_check (
  input  logic signed [p2g_pkg::V_W-1:0]     v_i,
  output logic        [p2g_pkg::COORD_W-1:0] coord_o,
  output logic                               ok_o
);
  import p2g_pkg::*;

  logic             neg;
  logic [V_W-1:0]   v_abs;
  logic [V_W-1:0]   v_sum;
  logic [INT_W-1:0] mag;

  assign neg   = v_i[V_W-1];
  assign v_abs = neg ? V_W'(-v_i) : V_W'(v_i);
  assign v_sum = v_abs + (V_W'(1) << (FRAC_W - 1));
  assign mag   = v_sum[V_W-1:FRAC_W];

  // a small negative value rounds to zero and stays on the grid
  assign ok_o    = (mag == '0) || (!neg && (mag < INT_W'(GRID_SIZE)));
  assign coord_o = neg ? '0 : COORD_W'(mag);

endmodule

// ===== hw/rtl/polar_to_grid_coordinate_unit.sv =====
// Polar to grid coordinate unit: angle and LED index in, grid pixel out.
// An accepted request passes through the input, trig, unrounded-coordinate and result registers.
// Throughput: one request per cycle; each stage stalls only when it and all
// stages after it are full, set by the output register and the downstream ready.
// Reset clears all valid bits and sets both centre registers to 32.
// Depends on p2g_pkg, p2g_cfg, p2g_trig_lookup and p2g_round_check.
module polar_to_grid_coordinate_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [8:0] angle_deg, [14:9] led_position, [15] zero
  input  logic [15:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [7:0] grid_x, [15:8] grid_y
  output logic [15:0]                m_axis_tdata,
  // [0] in_range
  output logic                       m_axis_tuser,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [p2g_pkg::APB_AW-1:0] paddr,
  input  logic [p2g_pkg::APB_DW-1:0] pwdata,
  output logic [p2g_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import p2g_pkg::*;

  cfg_t cfg;

  // stage 0: input register
  logic                valid0_q, valid0_d;
  logic [ANGLE_W-1:0]  angle0_q;
  logic [RADIUS_W-1:0] r0_q;
  // stage 1: trig values
  logic                     valid1_q, valid1_d;
  logic signed [TRIG_W-1:0] sin1_q, cos1_q;
  logic [RADIUS_W-1:0]      r1_q;
  logic                     rok1_q;
  // stage 2: unrounded coordinates
  logic                valid2_q, valid2_d;
  logic signed [V_W-1:0] vx2_q, vy2_q, vx2_d, vy2_d;
  logic                rok2_q;
  // stage 3: result register
  logic                valid3_q, valid3_d;
  logic [COORD_W-1:0]  x3_q, y3_q, x3_d, y3_d;
  logic                ok3_q, ok3_d;

  logic rdy0, rdy1, rdy2, rdy3;
  logic [ANGLE_W-1:0] deg_s, deg_c;
  logic signed [TRIG_W-1:0] sin_w, cos_w;
  logic signed [V_W-1:0] r_ext, cx_ext, cy_ext;
  logic [COORD_W-1:0] xr, yr;
  logic ok_x, ok_y;

  p2g_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // each stage frees up when empty or when the next one moves
  assign rdy3 = !valid3_q || m_axis_tready;
  assign rdy2 = !valid2_q || rdy3;
  assign rdy1 = !valid1_q || rdy2;
  assign rdy0 = !valid0_q || rdy1;
  assign s_axis_tready = rdy0;

  assign valid0_d = rdy0 ? s_axis_tvalid : valid0_q;
  assign valid1_d = rdy1 ? valid0_q : valid1_q;
  assign valid2_d = rdy2 ? valid1_q : valid2_q;
  assign valid3_d = rdy3 ? valid2_q : valid3_q;

  // angle wraps once, cosine is the sine a quarter turn on
  assign deg_s = (angle0_q >= ANGLE_W'(ANGLE_STEPS)) ? angle0_q - ANGLE_W'(ANGLE_STEPS)
                                                      : angle0_q;
  assign deg_c = (deg_s >= ANGLE_W'(3*QUARTER_DEG)) ? deg_s - ANGLE_W'(3*QUARTER_DEG)
                                                     : deg_s + ANGLE_W'(QUARTER_DEG);

  p2g_trig_lookup u_sin (
    .deg_i (deg_s),
    .sin_o (sin_w)
  );

  p2g_trig_lookup u_cos (
    .deg_i (deg_c),
    .sin_o (cos_w)
  );

  assign r_ext  = V_W'($signed({1'b0, r1_q}));
  assign cx_ext = $signed({(INT_W-CENTER_W)'(0), cfg.pivot_col, FRAC_W'(0)});
  assign cy_ext = $signed({(INT_W-CENTER_W)'(0), cfg.pivot_row, FRAC_W'(0)});
  assign vx2_d  = cx_ext + r_ext * V_W'(cos1_q);
  assign vy2_d  = cy_ext + r_ext * V_W'(sin1_q);

  p2g_round_check u_round_x (
    .v_i     (vx2_q),
    .coord_o (xr),
    .ok_o    (ok_x)
  );

  p2g_round_check u_round_y (
    .v_i     (vy2_q),
    .coord_o (yr),
    .ok_o    (ok_y)
  );

  assign ok3_d = ok_x && ok_y && rok2_q;
  assign x3_d  = ok3_d ? xr : '1;
  assign y3_d  = ok3_d ? yr : '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid0_q <= valid0_d;
      valid1_q <= valid1_d;
      valid2_q <= valid2_d;
      valid3_q <= valid3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      angle0_q <= s_axis_tdata[ANGLE_W-1:0];
      r0_q     <= s_axis_tdata[ANGLE_W+RADIUS_W-1:ANGLE_W];
    end
    if (rdy1) begin
      sin1_q <= sin_w;
      cos1_q <= cos_w;
      r1_q   <= r0_q;
      rok1_q <= {1'b0, r0_q} < (RADIUS_W+1)'(STRIP_LENGTH);
    end
    if (rdy2) begin
      vx2_q  <= vx2_d;
      vy2_q  <= vy2_d;
      rok2_q <= rok1_q;
    end
    if (rdy3) begin
      x3_q  <= x3_d;
      y3_q  <= y3_d;
      ok3_q <= ok3_d;
    end
  end

  assign m_axis_tvalid = valid3_q;
  assign m_axis_tdata  = {y3_q, x3_q};
  assign m_axis_tuser  = ok3_q;

`ifndef SYNTHESIS
  a_off_grid_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid3_q && !ok3_q |-> (x3_q == '1) && (y3_q == '1))
    else $error("off-grid result not marked with -1");

  a_on_grid_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid3_q && ok3_q |-> !x3_q[COORD_W-1] && !y3_q[COORD_W-1])
    else $error("in-range result has a negative coordinate");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> valid0_q && valid1_q && valid2_q && valid3_q)
    else $error("input stalled while a stage is empty");

  a_trig_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid1_q |-> (sin1_q <= (TRIG_W'(1) <<< FRAC_W)) && (sin1_q >= -(TRIG_W'(1) <<< FRAC_W))
              && (cos1_q <= (TRIG_W'(1) <<< FRAC_W)) && (cos1_q >= -(TRIG_W'(1) <<< FRAC_W)))
    else $error("trig value exceeds unit magnitude");
`endif

endmodule

// ===== dv/p2g_grid_checker.sv =====
// Checker for the polar to grid coordinate unit: watches the request, result and
// register channels, predicts each grid pixel and compares it. Uses p2g_pkg.
module p2g_grid_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic                       req_ready_i,
  input  logic [15:0]                req_data_i,
  input  logic                       pix_valid_i,
  input  logic                       pix_ready_i,
  input  logic [15:0]                pix_data_i,
  input  logic                       pix_user_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [p2g_pkg::APB_AW-1:0] paddr_i,
  input  logic [p2g_pkg::APB_DW-1:0] pwdata_i,
  output int unsigned                mismatches_o,
  output int unsigned                pending_o
);
  import p2g_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] gx;
    logic signed [COORD_W-1:0] gy;
    logic                      hit;
  } pixel_t;

  localparam int                  DEG_TURN     = 360;
  localparam int                  TAYLOR_TERMS = 14;
  localparam logic [CENTER_W-1:0] CENTER_RESET = 7'd32;
  localparam logic [63:0]         ONE_Q60      = 64'h1000_0000_0000_0000;
  localparam logic [63:0]         PI_Q60       = 64'h3243_F6A8_885A_308D;
  localparam longint              Q32_UNIT     = 64'sd4294967296;
  localparam longint              Q32_HALF     = 64'sd2147483648;

  longint              sin_tab [DEG_TURN];
  logic [CENTER_W-1:0] cx;
  logic [CENTER_W-1:0] cy;
  pixel_t              pixel_q [$];
  int unsigned         fails = 0;

  assign mismatches_o = fails;

  // (a * b) >> 60, kept to 64 bits
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] taylor_q60(logic [63:0] x, logic want_cos);
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] div;
    x2   = mul_q60(x, x);
    sum  = want_cos ? ONE_Q60 : x;
    term = sum;
    for (int i = 1; i <= TAYLOR_TERMS; i++) begin
      div  = want_cos ? 64'((2 * i - 1) * (2 * i)) : 64'((2 * i) * (2 * i + 1));
      term = mul_q60(term, x2) / div;
      if (i % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // first quadrant, sine up to 45 degrees and cosine of the complement above
  function automatic longint quarter_sin_q32(int m);
    logic [63:0] step;
    logic [63:0] v;
    step = PI_Q60 / 180;
    if (m <= 45) begin
      v = taylor_q60(64'(m) * step, 1'b0);
    end else begin
      v = taylor_q60(64'(QUARTER_DEG - m) * step, 1'b1);
    end
    return longint'((v + (64'd1 << 27)) >> 28);
  endfunction

  initial begin : build_sin_tab
    int     q;
    int     m;
    longint mag;
    for (int d = 0; d < DEG_TURN; d++) begin
      q   = d / QUARTER_DEG;
      m   = d % QUARTER_DEG;
      mag = (q % 2 == 1) ? quarter_sin_q32(QUARTER_DEG - m) : quarter_sin_q32(m);
      sin_tab[d] = (q >= 2) ? -mag : mag;
    end
  end

  function automatic longint round_half_away(logic [CENTER_W-1:0] c,
                                             logic [RADIUS_W-1:0] r, longint trig);
    longint v;
    v = longint'(c) * Q32_UNIT + longint'(r) * trig;
    if (v >= 0) begin
      return (v + Q32_HALF) / Q32_UNIT;
    end
    return -((-v + Q32_HALF) / Q32_UNIT);
  endfunction

  function automatic pixel_t predict_pixel(logic [ANGLE_W-1:0] ang, logic [RADIUS_W-1:0] r);
    int     deg;
    longint x;
    longint y;
    pixel_t p;
    deg   = (int'(ang) % ANGLE_STEPS) % DEG_TURN;
    x     = round_half_away(cx, r, sin_tab[(deg + QUARTER_DEG) % DEG_TURN]);
    y     = round_half_away(cy, r, sin_tab[deg]);
    p.hit = int'(r) < STRIP_LENGTH && x >= 0 && x < GRID_SIZE && y >= 0 && y < GRID_SIZE;
    p.gx  = p.hit ? COORD_W'(x) : '1;
    p.gy  = p.hit ? COORD_W'(y) : '1;
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_t want;
    pixel_t got;
    if (!rst_ni) begin
      cx = CENTER_RESET;
      cy = CENTER_RESET;
      pixel_q.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i >> 2))
          REG_CENTER_X: cx = pwdata_i[CENTER_W-1:0];
          REG_CENTER_Y: cy = pwdata_i[CENTER_W-1:0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        pixel_q.push_back(predict_pixel(req_data_i[ANGLE_W-1:0],
                                        req_data_i[ANGLE_W +: RADIUS_W]));
      end
      if (pix_valid_i && pix_ready_i) begin
        got.gx  = pix_data_i[COORD_W-1:0];
        got.gy  = pix_data_i[COORD_W +: COORD_W];
        got.hit = pix_user_i;
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("result x=%0d y=%0d hit=%0b with nothing pending",
                                    got.gx, got.gy, got.hit));
        end else begin
          want = pixel_q.pop_front();
          if (got.gx !== want.gx) begin
            report_mismatch($sformatf("grid_x %0d, expected %0d", got.gx, want.gx));
          end
          if (got.gy !== want.gy) begin
            report_mismatch($sformatf("grid_y %0d, expected %0d", got.gy, want.gy));
          end
          if (got.hit !== want.hit) begin
            report_mismatch($sformatf("in_range %0b, expected %0b", got.hit, want.hit));
          end
        end
      end
      pending_o <= pixel_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the polar to grid coordinate unit bench: clock, reset, requests, centre
// register writes and output back-pressure. Uses p2g_pkg and p2g_grid_checker.
module testbench;
  import p2g_pkg::*;

  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 180;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 10;
  localparam int DIRECTED_N   = 24;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;
  logic        hold_go = 1'b0;
  logic        hold_off = 1'b0;

  // angle / radius pairs: axes, diagonals, exact halves, wrapped angles, off grid
  int unsigned dir_angle [DIRECTED_N] = '{0, 0, 90, 180, 270, 359, 45, 30, 210, 150, 330,
                                          60, 120, 240, 300, 360, 400, 511, 135, 225, 315,
                                          1, 89, 181};
  int unsigned dir_led [DIRECTED_N] = '{0, 63, 63, 63, 63, 63, 63, 1, 1, 1, 1,
                                        3, 5, 7, 9, 10, 20, 63, 40, 45, 50,
                                        1, 62, 31};

  polar_to_grid_coordinate_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  p2g_grid_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .pix_valid_i  (m_axis_tvalid),
    .pix_ready_i  (m_axis_tready),
    .pix_data_i   (m_axis_tdata),
    .pix_user_i   (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (outstanding)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // long downstream hold-off so the pipeline fills and stalls its input
  initial begin
    @(posedge hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("polar_to_grid_coordinate_unit verification failed");
    $finish;
  end

  task automatic send_request(logic [ANGLE_W-1:0] ang, logic [RADIUS_W-1:0] led);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, led, ang};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CENTER_W-1:0] val);
    logic [APB_DW-1:0] noise;
    noise   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(idx));
    // upper bits carry junk, only the centre field must land
    pwdata  <= {noise[APB_DW-1:CENTER_W], val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned        pick;
    logic [ANGLE_W-1:0] ang;
    logic [RADIUS_W-1:0] led;
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIRECTED_N; k++) begin
      send_request(ANGLE_W'(dir_angle[k]), RADIUS_W'(dir_led[k]));
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cx = '0; cy = '0; end
        1: begin cx = '1; cy = '1; end
        2: begin cx = '0; cy = '1; end
        3: begin cx = '1; cy = '0; end
        default: begin
          cx = CENTER_W'($urandom_range(127));
          cy = CENTER_W'($urandom_range(127));
        end
      endcase
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      if (p == 4) begin
        hold_go <= 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          ang = ANGLE_W'(30 * $urandom_range(11));
        end else if (pick < 32) begin
          ang = ANGLE_W'($urandom_range(511, 360));
        end else begin
          ang = ANGLE_W'($urandom_range(359));
        end
        led = ($urandom_range(99) < 25) ? RADIUS_W'($urandom_range(3))
                                        : RADIUS_W'($urandom_range(63));
        send_request(ang, led);
      end
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("polar_to_grid_coordinate_unit verification clean");
    end else begin
      $display("polar_to_grid_coordinate_unit verification failed");
    end
    $finish;
  end

endmodule
